[rtl/core/subbox_address_generator_assert.svh]
// Assertion macros for the sub-box address generator.
// Used by sag_datapath and sag_controller; no other dependencies.
`ifndef SUBBOX_ADDRESS_GENERATOR_ASSERT_SVH
`define SUBBOX_ADDRESS_GENERATOR_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define SAG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define SAG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/sag_pkg.sv]
// Shared types and constants of the sub-box address generator.
// No dependencies; used by every module of the block.
`default_nettype none

package sag_pkg;

  localparam int LIN_W       = 48;  // linear index and packed bound width
  localparam int DIMS_W      = 3;   // dims_in_use register width
  localparam int CMD_W       = 2;
  localparam int DIM_W       = 2;
  localparam int OUT_COORD_W = 12;  // coordinate result field width
  localparam int NUM_OUT     = 4;   // coordinate result fields
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_NEXT  = 2'd1,
    CMD_INC   = 2'd2,
    CMD_DEC   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIMS_IN_USE = 3'd0,
    CFG_OUTER_LOWER = 3'd1,
    CFG_OUTER_UPPER = 3'd2,
    CFG_SUB_LOWER   = 3'd3,
    CFG_SUB_UPPER   = 3'd4
  } cfg_idx_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NOP        = 4'd0,
    DP_START_INIT = 4'd1,
    DP_START_TERM = 4'd2,
    DP_START_ACC  = 4'd3,
    DP_START_RUN  = 4'd4,
    DP_NEXT_FIRST = 4'd5,
    DP_NEXT_CHK   = 4'd6,
    DP_NEXT_SUB   = 4'd7,
    DP_INC        = 4'd8,
    DP_DEC        = 4'd9
  } dp_op_e;

  typedef struct packed {
    logic n_zero;    // no active dimension
    logic carry;     // selected dimension wraps on the next step
    logic idx_zero;  // walk index sits on the outermost dimension
  } dp_stat_t;

  typedef logic [NUM_OUT-1:0][OUT_COORD_W-1:0] coord_out_t;

endpackage

`default_nettype wire

[rtl/core/sag_datapath.sv]
// Datapath of the sub-box address generator: coordinates, strides, offset,
// shared multiplier. Depends on sag_pkg and the assertion macro header.
`default_nettype none
`include "subbox_address_generator_assert.svh"

module sag_datapath #(
  parameter int MAX_DIMS   = 4,
  parameter int COORD_BITS = 12
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire sag_pkg::dp_op_e                op_i,
  input  wire logic [sag_pkg::DIM_W-1:0]      dim_i,
  input  wire logic [sag_pkg::DIMS_W-1:0]     dims_in_use_i,
  input  wire logic [sag_pkg::LIN_W-1:0]      outer_lower_i,
  input  wire logic [sag_pkg::LIN_W-1:0]      outer_upper_i,
  input  wire logic [sag_pkg::LIN_W-1:0]      sub_lower_i,
  input  wire logic [sag_pkg::LIN_W-1:0]      sub_upper_i,
  output sag_pkg::dp_stat_t                   stat_o,
  output logic                                exists_o,
  output logic [sag_pkg::LIN_W-1:0]           flat_addr_o,
  output sag_pkg::coord_out_t                 coord_o
);

  localparam int LW = sag_pkg::LIN_W;
  localparam int IW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CW = $clog2(MAX_DIMS + 1);
  localparam int DW = COORD_BITS + 1;   // signed bound difference
  localparam int PW = LW + DW - 1;

  function automatic logic [COORD_BITS-1:0] fld(input logic [LW-1:0] p, input int d);
    logic [63:0] w;
    w = 64'(p) >> ((MAX_DIMS - 1 - d) * COORD_BITS);
    return w[COORD_BITS-1:0];
  endfunction

  logic [COORD_BITS-1:0] olo_f [MAX_DIMS];
  logic [COORD_BITS-1:0] ohi_f [MAX_DIMS];
  logic [COORD_BITS-1:0] slo_f [MAX_DIMS];
  logic [COORD_BITS-1:0] shi_f [MAX_DIMS];

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      olo_f[d] = fld(outer_lower_i, d);
      ohi_f[d] = fld(outer_upper_i, d);
      slo_f[d] = fld(sub_lower_i, d);
      shi_f[d] = fld(sub_upper_i, d);
    end
  end

  logic [MAX_DIMS-1:0][COORD_BITS-1:0] coord_q, coord_d;
  logic [MAX_DIMS-1:0][LW-1:0]         stride_q, stride_d;
  logic [LW-1:0]                       offset_q, offset_d;
  logic                                valid_q, valid_d;
  logic [LW-1:0]                       run_q, run_d;
  logic [LW-1:0]                       prod_q, prod_d;
  logic [IW-1:0]                       idx_q, idx_d;

  logic [CW-1:0]         act_n, act_m1;
  logic [IW-1:0]         last_idx, sel;
  logic                  n_zero, dim_ok, carry;
  logic [COORD_BITS-1:0] cur_coord, cur_olo, cur_ohi, cur_slo, cur_shi, coord_inc;
  logic [LW-1:0]         cur_stride;
  logic [DW-1:0]         mul_a;
  logic [LW-1:0]         mul_b, mul_res;
  logic [PW-1:0]         mul_full;

  // Clamp the dimension count to what the hardware holds.
  assign act_n    = (dims_in_use_i > (sag_pkg::DIMS_W)'(MAX_DIMS)) ? CW'(MAX_DIMS)
                                                                   : dims_in_use_i[CW-1:0];
  assign act_m1   = act_n - CW'(1);
  assign last_idx = act_m1[IW-1:0];
  assign n_zero   = (act_n == '0);
  assign dim_ok   = ((sag_pkg::DIMS_W)'(dim_i) < (sag_pkg::DIMS_W)'(act_n));

  always_comb begin
    case (op_i)
      sag_pkg::DP_INC, sag_pkg::DP_DEC: sel = dim_i[IW-1:0];
      sag_pkg::DP_NEXT_FIRST:           sel = last_idx;
      default:                          sel = idx_q;
    endcase
  end

  assign cur_coord  = coord_q[sel];
  assign cur_stride = stride_q[sel];
  assign cur_olo    = olo_f[sel];
  assign cur_ohi    = ohi_f[sel];
  assign cur_slo    = slo_f[sel];
  assign cur_shi    = shi_f[sel];
  assign coord_inc  = cur_coord + COORD_BITS'(1);
  assign carry      = (coord_inc == cur_shi);

  // Shared multiplier: signed bound difference times a 48-bit stride, mod 2^48.
  always_comb begin
    case (op_i)
      sag_pkg::DP_START_TERM: begin
        mul_a = {1'b0, cur_slo} - {1'b0, cur_olo};
        mul_b = run_q;
      end
      sag_pkg::DP_START_ACC: begin
        mul_a = {1'b0, cur_ohi} - {1'b0, cur_olo};
        mul_b = run_q;
      end
      default: begin
        mul_a = {1'b0, cur_shi} - {1'b0, cur_slo} - DW'(1);
        mul_b = cur_stride;
      end
    endcase
  end

  assign mul_full = PW'(mul_a[DW-2:0]) * PW'(mul_b);
  assign mul_res  = mul_full[LW-1:0] - (mul_a[DW-1] ? (mul_b << (DW - 1)) : '0);

  always_comb begin
    coord_d  = coord_q;
    stride_d = stride_q;
    offset_d = offset_q;
    valid_d  = valid_q;
    run_d    = run_q;
    prod_d   = prod_q;
    idx_d    = idx_q;
    case (op_i)
      sag_pkg::DP_START_INIT: begin
        coord_d  = '0;
        stride_d = '0;
        offset_d = '0;
        valid_d  = !n_zero;
        run_d    = LW'(1);
        idx_d    = last_idx;
      end
      sag_pkg::DP_START_TERM: begin
        coord_d[sel]  = cur_slo;
        stride_d[sel] = run_q;
        prod_d        = mul_res;
      end
      sag_pkg::DP_START_ACC: begin
        offset_d = offset_q + prod_q;
        prod_d   = mul_res;
      end
      sag_pkg::DP_START_RUN: begin
        run_d = prod_q;
        if (idx_q != '0) begin
          idx_d = idx_q - IW'(1);
        end
      end
      sag_pkg::DP_NEXT_FIRST, sag_pkg::DP_NEXT_CHK: begin
        if (op_i == sag_pkg::DP_NEXT_FIRST) begin
          idx_d = last_idx;
        end
        if ((op_i == sag_pkg::DP_NEXT_FIRST) && n_zero) begin
          valid_d = 1'b0;
        end else if (carry) begin
          coord_d[sel] = cur_slo;
          prod_d       = mul_res;
        end else begin
          coord_d[sel] = coord_inc;
          offset_d     = offset_q + cur_stride;
        end
      end
      sag_pkg::DP_NEXT_SUB: begin
        offset_d = offset_q - prod_q;
        if (idx_q == '0) begin
          valid_d = 1'b0;
        end else begin
          idx_d = idx_q - IW'(1);
        end
      end
      sag_pkg::DP_INC: begin
        if (dim_ok) begin
          coord_d[sel] = coord_inc;
          offset_d     = offset_q + cur_stride;
        end
      end
      sag_pkg::DP_DEC: begin
        if (dim_ok) begin
          coord_d[sel] = cur_coord - COORD_BITS'(1);
          offset_d     = offset_q - cur_stride;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_q  <= '0;
      stride_q <= '0;
      offset_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      coord_q  <= coord_d;
      stride_q <= stride_d;
      offset_q <= offset_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q  <= run_d;
    prod_q <= prod_d;
    idx_q  <= idx_d;
  end

  assign stat_o.n_zero   = n_zero;
  assign stat_o.carry    = carry;
  assign stat_o.idx_zero = (idx_q == '0);

  assign exists_o    = valid_q;
  assign flat_addr_o = offset_q;

  for (genvar g = 0; g < sag_pkg::NUM_OUT; g++) begin : g_coord_out
    if (g < MAX_DIMS) begin : g_live
      assign coord_o[g] = (sag_pkg::OUT_COORD_W)'(coord_q[g]);
    end else begin : g_zero
      assign coord_o[g] = '0;
    end
  end

  `SAG_ASSERT_NEXT(a_outer_wrap_clears, clk_i, rst_ni,
                   (op_i == sag_pkg::DP_NEXT_SUB) && (idx_q == '0), !valid_q,
                   "outer carry left point valid")
  `SAG_ASSERT(a_valid_from_start, clk_i, rst_ni,
              $rose(valid_q) |-> $past(op_i == sag_pkg::DP_START_INIT),
              "point became valid without start")

endmodule

`default_nettype wire

[rtl/core/sag_controller.sv]
// Controller state machine of the sub-box address generator.
// Depends on sag_pkg and the assertion macro header.
`default_nettype none
`include "subbox_address_generator_assert.svh"

module sag_controller (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [sag_pkg::CMD_W-1:0] cmd_i,
  input  wire sag_pkg::dp_stat_t         stat_i,
  output sag_pkg::dp_op_e                op_o,
  output logic                           busy_o,
  output logic                           done_o
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_ST_TERM = 6'b000010,
    S_ST_ACC  = 6'b000100,
    S_ST_RUN  = 6'b001000,
    S_NX_CHK  = 6'b010000,
    S_NX_SUB  = 6'b100000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    op_o    = sag_pkg::DP_NOP;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (cmd_i)
            sag_pkg::CMD_START: begin
              op_o = sag_pkg::DP_START_INIT;
              if (stat_i.n_zero) begin
                done_d = 1'b1;
              end else begin
                state_d = S_ST_TERM;
              end
            end
            sag_pkg::CMD_NEXT: begin
              op_o = sag_pkg::DP_NEXT_FIRST;
              if (stat_i.n_zero || !stat_i.carry) begin
                done_d = 1'b1;
              end else begin
                state_d = S_NX_SUB;
              end
            end
            sag_pkg::CMD_INC: begin
              op_o   = sag_pkg::DP_INC;
              done_d = 1'b1;
            end
            sag_pkg::CMD_DEC: begin
              op_o   = sag_pkg::DP_DEC;
              done_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_ST_TERM: begin
        op_o    = sag_pkg::DP_START_TERM;
        state_d = S_ST_ACC;
      end
      S_ST_ACC: begin
        op_o    = sag_pkg::DP_START_ACC;
        state_d = S_ST_RUN;
      end
      S_ST_RUN: begin
        op_o = sag_pkg::DP_START_RUN;
        if (stat_i.idx_zero) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_ST_TERM;
        end
      end
      S_NX_CHK: begin
        op_o = sag_pkg::DP_NEXT_CHK;
        if (stat_i.carry) begin
          state_d = S_NX_SUB;
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_NX_SUB: begin
        op_o = sag_pkg::DP_NEXT_SUB;
        if (stat_i.idx_zero) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_NX_CHK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  `SAG_ASSERT(a_done_when_idle, clk_i, rst_ni, done_q |-> (state_q == S_IDLE), "result strobe outside idle")
  `SAG_ASSERT_NEXT(a_move_one_cycle, clk_i, rst_ni, start_i && !busy_o && ((cmd_i == sag_pkg::CMD_INC) || (cmd_i == sag_pkg::CMD_DEC)), done_q, "move did not finish in one cycle")

endmodule

`default_nettype wire

[rtl/core/subbox_address_generator.sv]
// Top level of the sub-box address generator: configuration registers,
// controller and datapath. Depends on sag_pkg, sag_controller, sag_datapath.
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+-------------------------
//  command   | cmd_i, dim_i                            | start high, busy low
//  result    | exists_o, flat_addr_o, coord0..3_o      | done_o, one cycle, no stall
//  config    | cfg_idx_i, cfg_wdata_i                  | cfg_we_i, no wait
//
// Increment and decrement finish straight from idle. Next advances the innermost
// active dimension; each wrap passes through the subtract and check states to the
// next outer one, until one advances or all wrap and the walk ends. Start visits
// each active dimension, innermost first, through the term, accumulate and run
// states. This sequencing is set by the single shared multiplier, whose product
// is registered before it enters the offset adder, and by visiting one dimension
// per step. A new command may be accepted in the strobe cycle.
// Reset clears configuration, coordinates, strides, offset and the valid
// flag; busy is low right after reset. The receiver cannot hold off a beat.
`default_nettype none

module subbox_address_generator #(
  parameter int MAX_DIMS   = 4,
  parameter int COORD_BITS = 12
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // command beat
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [sag_pkg::CMD_W-1:0]           cmd_i,
  input  wire logic [sag_pkg::DIM_W-1:0]           dim_i,
  // result beat
  output logic                                     done_o,
  output logic                                     exists_o,
  output logic [sag_pkg::LIN_W-1:0]                flat_addr_o,
  output logic [sag_pkg::OUT_COORD_W-1:0]          coord0_o,
  output logic [sag_pkg::OUT_COORD_W-1:0]          coord1_o,
  output logic [sag_pkg::OUT_COORD_W-1:0]          coord2_o,
  output logic [sag_pkg::OUT_COORD_W-1:0]          coord3_o,
  // configuration writes
  input  wire logic                                cfg_we_i,
  input  wire logic [sag_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [sag_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  logic [sag_pkg::DIMS_W-1:0] dims_q;
  logic [sag_pkg::LIN_W-1:0]  outer_lower_q, outer_upper_q, sub_lower_q, sub_upper_q;

  // Register file: drop writes to indexes past the last register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q        <= '0;
      outer_lower_q <= '0;
      outer_upper_q <= '0;
      sub_lower_q   <= '0;
      sub_upper_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sag_pkg::CFG_DIMS_IN_USE: dims_q        <= cfg_wdata_i[sag_pkg::DIMS_W-1:0];
        sag_pkg::CFG_OUTER_LOWER: outer_lower_q <= cfg_wdata_i[sag_pkg::LIN_W-1:0];
        sag_pkg::CFG_OUTER_UPPER: outer_upper_q <= cfg_wdata_i[sag_pkg::LIN_W-1:0];
        sag_pkg::CFG_SUB_LOWER:   sub_lower_q   <= cfg_wdata_i[sag_pkg::LIN_W-1:0];
        sag_pkg::CFG_SUB_UPPER:   sub_upper_q   <= cfg_wdata_i[sag_pkg::LIN_W-1:0];
        default: ;
      endcase
    end
  end

  sag_pkg::dp_op_e     dp_op;
  sag_pkg::dp_stat_t   dp_stat;
  sag_pkg::coord_out_t coord_out;

  // Sequence start and next over the dimensions, innermost first.
  sag_controller u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_i   (cmd_i),
    .stat_i  (dp_stat),
    .op_o    (dp_op),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // Hold the walk state; results are read straight from its registers.
  sag_datapath #(
    .MAX_DIMS   (MAX_DIMS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (dp_op),
    .dim_i          (dim_i),
    .dims_in_use_i  (dims_q),
    .outer_lower_i  (outer_lower_q),
    .outer_upper_i  (outer_upper_q),
    .sub_lower_i    (sub_lower_q),
    .sub_upper_i    (sub_upper_q),
    .stat_o         (dp_stat),
    .exists_o       (exists_o),
    .flat_addr_o    (flat_addr_o),
    .coord_o        (coord_out)
  );

  assign coord0_o = coord_out[0];
  assign coord1_o = coord_out[1];
  assign coord2_o = coord_out[2];
  assign coord3_o = coord_out[3];

endmodule

`default_nettype wire
